// File: rtl/jsm_pkg.sv
// ----------------------------------------------------------------------------
// jsm_pkg
// Shared types and constants of the JTAG scan master.
// ----------------------------------------------------------------------------
package jsm_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = 6;
	localparam int IDX_W      = $clog2(DATA_WIDTH);
	localparam int CFG_W      = 5;

	localparam logic [CNT_W-1:0] MAX_CNT         = CNT_W'(DATA_WIDTH);
	localparam logic [CNT_W-1:0] RESET_TMS_HIGH  = CNT_W'(5);
	localparam logic [CNT_W-1:0] ENTRY_LEN_IR    = CNT_W'(4);
	localparam logic [CNT_W-1:0] ENTRY_LEN_DR    = CNT_W'(3);

	typedef enum logic [1:0] {
		CMD_TAP_RESET = 2'd0,
		CMD_IR_SCAN   = 2'd1,
		CMD_DR_SCAN   = 2'd2,
		CMD_TICK      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_RESET  = 3'd1,
		PH_ENTRY  = 3'd2,
		PH_SHIFT  = 3'd3,
		PH_UPDATE = 3'd4
	} phase_t;

	typedef enum logic {
		CFG_TDI_IDLE   = 1'b0,
		CFG_STATUS_BIT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic             tdi_idle;
		logic [IDX_W-1:0] status_idx;
	} cfg_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [DATA_WIDTH-1:0] data;
		logic [CNT_W-1:0]      count;
		logic                  keep;
		logic                  tdo;
	} item_t;

	typedef struct packed {
		logic                  pin_valid;
		logic                  tms;
		logic                  tdi;
		logic                  scan_done;
		logic [DATA_WIDTH-1:0] captured;
		logic                  debug_mode;
		logic                  rejected;
	} result_t;

endpackage

// File: rtl/jsm_front.sv
// ----------------------------------------------------------------------------
// jsm_front
// Accepts requests, normalizes the bit count and queues them (two entries).
// ----------------------------------------------------------------------------
module jsm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    cmd,
	input  logic [jsm_pkg::DATA_WIDTH-1:0] shift_data,
	input  logic [jsm_pkg::CNT_W-1:0]     bit_count,
	input  logic                          keep_shifting,
	input  logic                          tdo,
	output jsm_pkg::item_t                item,
	output logic                          item_valid,
	input  logic                          item_take
);
	import jsm_pkg::*;

	item_t      q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       do_push;
	logic       do_pop;

	// clamp the segment length to 1..DATA_WIDTH
	always_comb begin
		cls.cmd  = cmd_t'(cmd);
		cls.data = shift_data;
		cls.keep = keep_shifting;
		cls.tdo  = tdo;
		if (bit_count == '0) begin
			cls.count = CNT_W'(1);
		end else if (bit_count > MAX_CNT) begin
			cls.count = MAX_CNT;
		end else begin
			cls.count = bit_count;
		end
	end

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = q_mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/jsm_resq.sv
// ----------------------------------------------------------------------------
// jsm_resq
// Two-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module jsm_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  jsm_pkg::result_t res_in,
	output logic             res_ready,
	input  logic             pop,
	output logic             empty,
	output jsm_pkg::result_t res_out
);
	import jsm_pkg::*;

	result_t    q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign empty     = (cnt_q == 2'd0);
	assign do_pop    = pop && !empty;
	// a full queue still takes a request in the cycle its head leaves
	assign res_ready = (cnt_q != 2'd2) || do_pop;
	assign do_push   = res_push && res_ready;
	assign res_out   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/jsm_engine.sv
// ----------------------------------------------------------------------------
// jsm_engine
// TAP sequencer: runs one queued request per clock while the result queue has room, and forms its result.
// ----------------------------------------------------------------------------
module jsm_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  jsm_pkg::cfg_t    cfg,
	input  jsm_pkg::item_t   item,
	input  logic             item_valid,
	output logic             item_take,
	output logic             res_push,
	output jsm_pkg::result_t res,
	input  logic             res_ready
);
	import jsm_pkg::*;

	phase_t                phase_q, phase_n;
	logic [CNT_W-1:0]      step_q, step_n;
	logic [DATA_WIDTH-1:0] out_shift_q, out_shift_n;
	logic [DATA_WIDTH-1:0] in_shift_q, in_shift_n;
	logic [CNT_W-1:0]      bits_left_q, bits_left_n;
	logic                  is_ir_q, is_ir_n;
	logic                  hold_q, hold_n;
	logic                  in_dr_q, in_dr_n;
	logic [CNT_W-1:0]      step_inc;
	logic                  seg_end;

	assign item_take = item_valid && res_ready;
	assign res_push  = item_take;
	assign step_inc  = step_q + CNT_W'(1);
	assign seg_end   = (bits_left_q <= CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			step_q      <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			bits_left_q <= '0;
			is_ir_q     <= 1'b0;
			hold_q      <= 1'b0;
			in_dr_q     <= 1'b0;
		end else begin
			phase_q     <= phase_n;
			step_q      <= step_n;
			out_shift_q <= out_shift_n;
			in_shift_q  <= in_shift_n;
			bits_left_q <= bits_left_n;
			is_ir_q     <= is_ir_n;
			hold_q      <= hold_n;
			in_dr_q     <= in_dr_n;
		end
	end

	always_comb begin
		phase_n     = phase_q;
		step_n      = step_q;
		out_shift_n = out_shift_q;
		in_shift_n  = in_shift_q;
		bits_left_n = bits_left_q;
		is_ir_n     = is_ir_q;
		hold_n      = hold_q;
		in_dr_n     = in_dr_q;
		res         = '0;

		if (item_take) begin
			if (item.cmd != CMD_TICK) begin
				// scan commands start only from idle; no IR while parked in Shift-DR
				if (phase_q != PH_IDLE || (item.cmd == CMD_IR_SCAN && in_dr_q)) begin
					res.rejected = 1'b1;
				end else begin
					step_n     = '0;
					in_shift_n = '0;
					unique case (item.cmd)
						CMD_TAP_RESET: begin
							phase_n = PH_RESET;
							in_dr_n = 1'b0;
							hold_n  = 1'b0;
							is_ir_n = 1'b0;
						end
						CMD_IR_SCAN: begin
							bits_left_n = item.count;
							out_shift_n = item.data;
							is_ir_n     = 1'b1;
							hold_n      = 1'b0;
							phase_n     = PH_ENTRY;
						end
						default: begin
							bits_left_n = item.count;
							out_shift_n = item.data;
							is_ir_n     = 1'b0;
							hold_n      = item.keep;
							// parked in Shift-DR: skip the entry walk
							phase_n     = in_dr_q ? PH_SHIFT : PH_ENTRY;
						end
					endcase
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						phase_n = PH_IDLE;
					end
					PH_RESET: begin
						res.pin_valid = 1'b1;
						res.tdi       = cfg.tdi_idle;
						if (step_q >= RESET_TMS_HIGH) begin
							res.tms       = 1'b0;
							res.scan_done = 1'b1;
							phase_n       = PH_IDLE;
							step_n        = '0;
						end else begin
							res.tms = 1'b1;
							step_n  = step_inc;
						end
					end
					PH_ENTRY: begin
						res.pin_valid = 1'b1;
						res.tdi       = cfg.tdi_idle;
						res.tms       = (step_q == '0) || (is_ir_q && step_q == CNT_W'(1));
						if (step_inc >= (is_ir_q ? ENTRY_LEN_IR : ENTRY_LEN_DR)) begin
							phase_n = PH_SHIFT;
							step_n  = '0;
						end else begin
							step_n = step_inc;
						end
					end
					PH_SHIFT: begin
						res.pin_valid = 1'b1;
						res.tdi       = out_shift_q[0];
						res.tms       = seg_end && !hold_q;
						in_shift_n    = in_shift_q
							| (DATA_WIDTH'(item.tdo) << step_q[IDX_W-1:0]);
						out_shift_n   = out_shift_q >> 1;
						step_n        = step_inc;
						if (bits_left_q != '0) begin
							bits_left_n = bits_left_q - CNT_W'(1);
						end
						if (seg_end) begin
							if (hold_q) begin
								phase_n       = PH_IDLE;
								in_dr_n       = 1'b1;
								step_n        = '0;
								res.scan_done = 1'b1;
								res.captured  = in_shift_n;
							end else begin
								phase_n = PH_UPDATE;
							end
						end
					end
					PH_UPDATE: begin
						res.pin_valid  = 1'b1;
						res.tms        = 1'b1;
						res.tdi        = cfg.tdi_idle;
						res.scan_done  = 1'b1;
						res.captured   = in_shift_q;
						res.debug_mode = is_ir_q && in_shift_q[cfg.status_idx];
						phase_n        = PH_IDLE;
						in_dr_n        = 1'b0;
						step_n         = '0;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end
	end

`ifndef SYNTH
	a_shift_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SHIFT |-> bits_left_q != '0)
		else $error("shift phase with no bits left");

	a_update_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_UPDATE && item_take && item.cmd == CMD_TICK) |=> phase_q == PH_IDLE)
		else $error("update tick did not return to idle");

	a_no_ir_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(in_dr_q && phase_q != PH_IDLE) |-> !is_ir_q)
		else $error("IR scan running while parked in Shift-DR");

	a_entry_step: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ENTRY |-> step_q < ENTRY_LEN_IR)
		else $error("entry walk step out of range");
`endif

endmodule

// File: rtl/jtag_scan_master_top.sv
// ----------------------------------------------------------------------------
// jtag_scan_master_top
// JTAG TAP master shift engine with queue-style request and result ports.
// ----------------------------------------------------------------------------
// Every request (TAP reset, IR scan, DR scan or one TCK tick) gives exactly
// one result, in order. Scan commands load the sequencer and are accepted
// only when it is idle (otherwise the result has rejected set); each tick
// request then drives its TCK pulse and reports pin_valid, tms and tdi for
// it, samples its tdo into the capture word in the shift phase, and flags
// scan_done on the tick that ends the command, with captured (and
// debug_mode for IR scans) valid there. A TAP reset takes six ticks, an IR
// scan 4 + bit_count + 1, a DR scan 3 + bit_count + 1; a DR segment with
// keep_shifting set ends in Shift-DR after its entry walk (3 ticks, none
// when already parked) and bit_count shift ticks, and the next DR scan
// shifts at once. Throughput is one request per clock while the result
// queue has room: the sequencer retires one queued request per cycle, and
// its state update is the only loop. A request's result reaches the result
// port after passing the request queue and then the result queue (the
// sequencer takes it from the request queue and writes its result into the
// result queue); both queues hold two entries, so either side may stall on
// its own. Write the configuration registers only while no request is in
// flight.
// ----------------------------------------------------------------------------
module jtag_scan_master_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// request side
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     cmd,
	input  logic [jsm_pkg::DATA_WIDTH-1:0] shift_data,
	input  logic [jsm_pkg::CNT_W-1:0]      bit_count,
	input  logic                           keep_shifting,
	input  logic                           tdo,
	// result side
	output logic                           empty,
	input  logic                           pop,
	output logic                           pin_valid,
	output logic                           tms,
	output logic                           tdi,
	output logic                           scan_done,
	output logic [jsm_pkg::DATA_WIDTH-1:0] captured,
	output logic                           debug_mode,
	output logic                           rejected,
	// configuration
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [jsm_pkg::CFG_W-1:0]      cfg_wdata
);
	import jsm_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	logic    item_valid;
	logic    item_take;
	logic    res_push;
	logic    res_ready;
	result_t res_eng;
	result_t res_head;

	// config registers: index 0 = idle TDI level, index 1 = status bit select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tdi_idle   <= 1'b1;
			cfg_q.status_idx <= IDX_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TDI_IDLE:   cfg_q.tdi_idle   <= cfg_wdata[0];
				CFG_STATUS_BIT: cfg_q.status_idx <= cfg_wdata[IDX_W-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// front: classify and buffer requests
	jsm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.shift_data    (shift_data),
		.bit_count     (bit_count),
		.keep_shifting (keep_shifting),
		.tdo           (tdo),
		.item          (item),
		.item_valid    (item_valid),
		.item_take     (item_take)
	);

	// back: TAP sequencer
	jsm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.res_push   (res_push),
		.res        (res_eng),
		.res_ready  (res_ready)
	);

	// results wait here until popped
	jsm_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_in    (res_eng),
		.res_ready (res_ready),
		.pop       (pop),
		.empty     (empty),
		.res_out   (res_head)
	);

	assign pin_valid  = res_head.pin_valid;
	assign tms        = res_head.tms;
	assign tdi        = res_head.tdi;
	assign scan_done  = res_head.scan_done;
	assign captured   = res_head.captured;
	assign debug_mode = res_head.debug_mode;
	assign rejected   = res_head.rejected;

endmodule

// File: dv/jtag_scan_master_top_test.sv
// ----------------------------------------------------------------------------
// jtag_scan_master_top_test
// Self-checking bench for the JTAG scan master.
// ----------------------------------------------------------------------------
// Requests go in through the push/full queue port and results come out through
// the empty/pop port. A scoreboard class keeps its own copy of the TAP
// sequencer and the two config registers, predicts the pin result of every
// accepted request and matches it field by field against what pops out, in
// order. The run opens with a short directed pass, then random scan sequences
// under several config settings and sender/receiver idle mixes. One phase
// holds the receiver off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module jtag_scan_master_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import jsm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	// ------------------------------------------------------------------------
	// Scoreboard: TAP sequencer copy plus the queue of pin results still due
	// ------------------------------------------------------------------------
	class scan_scoreboard;
		logic                  tdi_idle;
		logic [IDX_W-1:0]      status_idx;
		phase_t                phase;
		logic [CNT_W-1:0]      step;
		logic [DATA_WIDTH-1:0] out_bits;
		logic [DATA_WIDTH-1:0] in_bits;
		logic [CNT_W-1:0]      bits_left;
		bit                    is_ir;
		bit                    hold;
		bit                    in_sdr;
		result_t               pins_due[$];
		int unsigned           mismatches;

		function new();
			tdi_idle   = 1'b1;
			status_idx = IDX_W'(2);
			phase      = PH_IDLE;
			step       = '0;
			out_bits   = '0;
			in_bits    = '0;
			bits_left  = '0;
			is_ir      = 1'b0;
			hold       = 1'b0;
			in_sdr     = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			if (idx == CFG_TDI_IDLE)
				tdi_idle = val[0];
			else
				status_idx = val[IDX_W-1:0];
		endfunction

		function bit engine_idle();
			return phase == PH_IDLE;
		endfunction

		function bit held_in_shift_dr();
			return in_sdr;
		endfunction

		function int pending();
			return pins_due.size();
		endfunction

		// one TCK step (or command load) of the sequencer
		function result_t next_pins(item_t it);
			result_t          r;
			logic [CNT_W-1:0] n;
			bit               last;
			r = '0;
			if (it.cmd != CMD_TICK) begin
				if (phase != PH_IDLE || (it.cmd == CMD_IR_SCAN && in_sdr)) begin
					r.rejected = 1'b1;
					return r;
				end
				step    = '0;
				in_bits = '0;
				if (it.cmd == CMD_TAP_RESET) begin
					phase  = PH_RESET;
					in_sdr = 1'b0;
					hold   = 1'b0;
					is_ir  = 1'b0;
				end else begin
					n = it.count;
					if (n == 0)
						n = CNT_W'(1);
					if (n > MAX_CNT)
						n = MAX_CNT;
					bits_left = n;
					out_bits  = it.data;
					is_ir     = (it.cmd == CMD_IR_SCAN);
					hold      = !is_ir && it.keep;
					// a DR scan that finds the TAP parked in Shift-DR shifts at once
					phase     = (!is_ir && in_sdr) ? PH_SHIFT : PH_ENTRY;
				end
				return r;
			end
			case (phase)
				PH_RESET: begin
					r.pin_valid = 1'b1;
					r.tdi       = tdi_idle;
					r.tms       = (step < RESET_TMS_HIGH);
					if (step >= RESET_TMS_HIGH) begin
						phase       = PH_IDLE;
						step        = '0;
						r.scan_done = 1'b1;
					end else
						step++;
				end
				PH_ENTRY: begin
					r.pin_valid = 1'b1;
					r.tdi       = tdi_idle;
					r.tms       = (step == 0) || (is_ir && step == 1);
					step++;
					if (step >= (is_ir ? ENTRY_LEN_IR : ENTRY_LEN_DR)) begin
						phase = PH_SHIFT;
						step  = '0;
					end
				end
				PH_SHIFT: begin
					last        = (bits_left <= 1);
					r.pin_valid = 1'b1;
					r.tdi       = out_bits[step];
					r.tms       = last && !hold;
					in_bits     = in_bits | (DATA_WIDTH'(it.tdo) << step);
					step++;
					if (bits_left > 0)
						bits_left--;
					if (last) begin
						if (hold) begin
							phase       = PH_IDLE;
							in_sdr      = 1'b1;
							step        = '0;
							r.scan_done = 1'b1;
							r.captured  = in_bits;
						end else
							phase = PH_UPDATE;
					end
				end
				PH_UPDATE: begin
					r.pin_valid  = 1'b1;
					r.tms        = 1'b1;
					r.tdi        = tdi_idle;
					r.scan_done  = 1'b1;
					r.captured   = in_bits;
					r.debug_mode = is_ir ? in_bits[status_idx] : 1'b0;
					phase        = PH_IDLE;
					in_sdr       = 1'b0;
					step         = '0;
				end
				default:
					phase = PH_IDLE;
			endcase
			return r;
		endfunction

		function result_t log_request(item_t it);
			result_t r;
			r = next_pins(it);
			pins_due.push_back(r);
			return r;
		endfunction

		function void check_pins(result_t got);
			result_t want;
			if (pins_due.size() == 0) begin
				$error("result popped with nothing outstanding");
				mismatches++;
				return;
			end
			want = pins_due.pop_front();
			if (got.pin_valid !== want.pin_valid) begin
				$error("pin_valid: expected %0b, got %0b", want.pin_valid, got.pin_valid);
				mismatches++;
			end
			if (got.tms !== want.tms) begin
				$error("tms: expected %0b, got %0b", want.tms, got.tms);
				mismatches++;
			end
			if (got.tdi !== want.tdi) begin
				$error("tdi: expected %0b, got %0b", want.tdi, got.tdi);
				mismatches++;
			end
			if (got.scan_done !== want.scan_done) begin
				$error("scan_done: expected %0b, got %0b", want.scan_done, got.scan_done);
				mismatches++;
			end
			if (got.captured !== want.captured) begin
				$error("captured: expected %h, got %h", want.captured, got.captured);
				mismatches++;
			end
			if (got.debug_mode !== want.debug_mode) begin
				$error("debug_mode: expected %0b, got %0b", want.debug_mode, got.debug_mode);
				mismatches++;
			end
			if (got.rejected !== want.rejected) begin
				$error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and DUT
	// ------------------------------------------------------------------------
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  push          = 1'b0;
	logic                  full;
	logic [1:0]            cmd           = '0;
	logic [DATA_WIDTH-1:0] shift_data    = '0;
	logic [CNT_W-1:0]      bit_count     = '0;
	logic                  keep_shifting = 1'b0;
	logic                  tdo           = 1'b0;
	logic                  empty;
	logic                  pop           = 1'b0;
	logic                  pin_valid;
	logic                  tms;
	logic                  tdi;
	logic                  scan_done;
	logic [DATA_WIDTH-1:0] captured;
	logic                  debug_mode;
	logic                  rejected;
	logic                  cfg_we        = 1'b0;
	logic                  cfg_index     = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata     = '0;

	always #5 clk = ~clk;

	jtag_scan_master_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.shift_data    (shift_data),
		.bit_count     (bit_count),
		.keep_shifting (keep_shifting),
		.tdo           (tdo),
		.empty         (empty),
		.pop           (pop),
		.pin_valid     (pin_valid),
		.tms           (tms),
		.tdi           (tdi),
		.scan_done     (scan_done),
		.captured      (captured),
		.debug_mode    (debug_mode),
		.rejected      (rejected),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	scan_scoreboard sb = new();

	// idle mix, changed per phase by the main sequence
	int unsigned tx_idle_pct   = 0;
	int unsigned rx_stall_pct  = 0;
	// long receiver hold-off, counted down by the receiver itself
	int unsigned rx_hold_left  = 0;
	// requests that did real work (idle ticks and rejects not counted)
	int unsigned useful_sent   = 0;
	int unsigned cycle_count   = 0;

	// ------------------------------------------------------------------------
	// Receiver: pop driven on the falling edge, results checked on the rising
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			pop <= 1'b0;
			rx_hold_left--;
		end else
			pop <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && pop && !empty) begin
			got.pin_valid  = pin_valid;
			got.tms        = tms;
			got.tdi        = tdi;
			got.scan_done  = scan_done;
			got.captured   = captured;
			got.debug_mode = debug_mode;
			got.rejected   = rejected;
			sb.check_pins(got);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[jtag_scan_master_top] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Request driver. Called at a falling edge, returns at a falling edge with
	// push still high; the caller's next drive (or settle) sets push again, so
	// push sees exactly one assignment per edge.
	// ------------------------------------------------------------------------
	task automatic send_req(cmd_t c, logic [DATA_WIDTH-1:0] d, logic [CNT_W-1:0] n,
			logic k);
		item_t   it;
		result_t due;
		it.cmd   = c;
		it.data  = d;
		it.count = n;
		it.keep  = k;
		it.tdo   = 1'($urandom_range(0, 1));
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push          <= 1'b1;
		cmd           <= it.cmd;
		shift_data    <= it.data;
		bit_count     <= it.count;
		keep_shifting <= it.keep;
		tdo           <= it.tdo;
		@(posedge clk);
		while (full)
			@(posedge clk);
		due = sb.log_request(it);
		if (due.pin_valid || (!due.rejected && c != CMD_TICK))
			useful_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_req(CMD_TICK, $urandom, CNT_W'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)));
	endtask

	// tick the sequencer until the current command is done; now and then a
	// command is slipped in mid-scan, which the block must reject
	task automatic finish_ticks(int unsigned intrude_pct);
		int guard = 0;
		while (!sb.engine_idle() && guard < 64) begin
			if ($urandom_range(0, 99) < intrude_pct)
				send_req(cmd_t'($urandom_range(0, 2)), $urandom,
					CNT_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			else
				send_tick();
			guard++;
		end
	endtask

	// mostly short segments so the run stays quick, some longer up to the full width, a few
	// out of range (zero and above the data width)
	function automatic logic [CNT_W-1:0] pick_count();
		int unsigned r = $urandom_range(0, 99);
		if (r < 75)
			return CNT_W'($urandom_range(1, 10));
		if (r < 93)
			return CNT_W'($urandom_range(11, 32));
		return CNT_W'($urandom_range(0, 63));
	endfunction

	// wait for every outstanding result
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic program_regs(logic idle_level, logic [IDX_W-1:0] status_bit);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TDI_IDLE;
		cfg_wdata <= CFG_W'(idle_level);
		sb.write_reg(CFG_TDI_IDLE, CFG_W'(idle_level));
		@(negedge clk);
		cfg_index <= CFG_STATUS_BIT;
		cfg_wdata <= CFG_W'(status_bit);
		sb.write_reg(CFG_STATUS_BIT, CFG_W'(status_bit));
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// well-formed scan sequences with random content, plus noise
	task automatic run_random(int unsigned target);
		int unsigned start;
		int unsigned r;
		start = useful_sent;
		while (useful_sent - start < target) begin
			r = $urandom_range(0, 99);
			// parked in Shift-DR: mostly continue the chain
			if (sb.held_in_shift_dr() && r < 60)
				r = 30;
			if (r < 8)
				send_req(CMD_TAP_RESET, $urandom, pick_count(), 1'($urandom_range(0, 1)));
			else if (r < 50)
				send_req(CMD_DR_SCAN, $urandom, pick_count(), $urandom_range(0, 2) == 0);
			else if (r < 88)
				send_req(CMD_IR_SCAN, $urandom, pick_count(), 1'($urandom_range(0, 1)));
			else
				send_req(cmd_t'($urandom_range(0, 3)), $urandom,
					CNT_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			finish_ticks(3);
			// stray tick while idle or parked
			if ($urandom_range(0, 9) == 0)
				send_tick();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset register values
		send_tick();                                   // tick with nothing loaded
		send_req(CMD_TAP_RESET, '0, '0, 1'b0);
		finish_ticks(0);
		send_req(CMD_IR_SCAN, '1, '0, 1'b1);           // zero count, keep ignored
		send_tick();
		send_req(CMD_DR_SCAN, '1, 6'd5, 1'b0);         // busy: rejected
		finish_ticks(0);
		send_req(CMD_DR_SCAN, '0, 6'd1, 1'b1);         // park in Shift-DR
		finish_ticks(0);
		send_req(CMD_IR_SCAN, '1, 6'd63, 1'b0);        // IR while parked: rejected
		send_req(CMD_DR_SCAN, '1, 6'd2, 1'b0);         // no entry walk, then exit
		finish_ticks(0);
		settle();

		// no idling, low TDI idle, status from bit 0
		program_regs(1'b0, IDX_W'(0));
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		run_random(150);
		settle();

		// sparse sender, status from the top bit
		program_regs(1'b1, IDX_W'(31));
		tx_idle_pct  = 85;
		rx_stall_pct = 0;
		run_random(150);
		settle();

		// slow receiver
		program_regs(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 31)));
		tx_idle_pct  = 0;
		rx_stall_pct = 85;
		run_random(150);
		settle();

		// both sides idling
		program_regs(1'b0, IDX_W'($urandom_range(0, 31)));
		tx_idle_pct  = 29;
		rx_stall_pct = 29;
		run_random(150);
		settle();

		// back-pressure: receiver holds off while the sender keeps pushing
		program_regs(1'b1, IDX_W'(2));
		tx_idle_pct  = 0;
		rx_stall_pct = 10;
		rx_hold_left = 300;
		run_random(150);
		settle();

		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[jtag_scan_master_top] OK");
		else
			$display("[jtag_scan_master_top] ERROR");
		$finish;
	end

endmodule

// File: files.f
rtl/jsm_pkg.sv
rtl/jsm_front.sv
rtl/jsm_resq.sv
rtl/jsm_engine.sv
rtl/jtag_scan_master_top.sv
dv/jtag_scan_master_top_test.sv
